### design/i2c_message_sequencer_assert.svh
// Assertion macros for the message sequencer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef I2C_MESSAGE_SEQUENCER_ASSERT_SVH
`define I2C_MESSAGE_SEQUENCER_ASSERT_SVH

// Checked at every edge out of reset.
`define IMS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Checked at every edge, reset included.
`define IMS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### design/ims_pkg.sv
// Shared types, codes and widths of the message sequencer.
// No dependencies; imported by every other design file but the assertion header.
package ims_pkg;

  localparam int MSG_BYTES_DEF = 5;

  localparam int OP_W     = 2;
  localparam int IDX_IN_W = 3;
  localparam int BYTE_W   = 8;
  localparam int ACT_W    = 3;
  localparam int LINK_W   = 3;
  localparam int CNT_W    = 8;
  localparam int KIND_W   = 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_EVENT  = 2'd1;
  localparam logic [OP_W-1:0] OP_FETCH  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd4;

  localparam logic [LINK_W-1:0] LINK_OFF     = 3'd0;
  localparam logic [LINK_W-1:0] LINK_RCV_ON  = 3'd1;
  localparam logic [LINK_W-1:0] LINK_RCV_END = 3'd2;
  localparam logic [LINK_W-1:0] LINK_SND_ON  = 3'd3;
  localparam logic [LINK_W-1:0] LINK_SND_END = 3'd4;

  // Controller status codes, prescaler bits masked
  localparam logic [BYTE_W-1:0] ST_START      = 8'h08;
  localparam logic [BYTE_W-1:0] ST_RESTART    = 8'h10;
  localparam logic [BYTE_W-1:0] ST_MT_SLA_ACK = 8'h18;
  localparam logic [BYTE_W-1:0] ST_MT_DAT_ACK = 8'h28;
  localparam logic [BYTE_W-1:0] ST_ARB_LOST   = 8'h38;
  localparam logic [BYTE_W-1:0] ST_SR_SLA     = 8'h60;
  localparam logic [BYTE_W-1:0] ST_SR_ARB_SLA = 8'h68;
  localparam logic [BYTE_W-1:0] ST_SR_GCALL   = 8'h70;
  localparam logic [BYTE_W-1:0] ST_SR_ARB_GC  = 8'h78;
  localparam logic [BYTE_W-1:0] ST_SR_DATA    = 8'h80;
  localparam logic [BYTE_W-1:0] ST_SR_GC_DATA = 8'h90;
  localparam logic [BYTE_W-1:0] ST_SR_STOP    = 8'hA0;

  // Command kinds produced by the front end
  localparam logic [KIND_W-1:0] K_WRITE     = 4'd0;
  localparam logic [KIND_W-1:0] K_WRITE_GO  = 4'd1;
  localparam logic [KIND_W-1:0] K_FETCH     = 4'd2;
  localparam logic [KIND_W-1:0] K_RX_STOP   = 4'd3;
  localparam logic [KIND_W-1:0] K_RX_DATA   = 4'd4;
  localparam logic [KIND_W-1:0] K_RX_FIRST  = 4'd5;
  localparam logic [KIND_W-1:0] K_MST_NEXT  = 4'd6;
  localparam logic [KIND_W-1:0] K_MST_FIRST = 4'd7;
  localparam logic [KIND_W-1:0] K_ARB       = 4'd8;
  localparam logic [KIND_W-1:0] K_OTHER     = 4'd9;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [IDX_IN_W-1:0] idx;
    logic [BYTE_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### design/ims_req_if.sv
// Input channel of the message sequencer: valid/ready plus item fields.
// Depends on ims_pkg.
interface ims_req_if;
  import ims_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [IDX_IN_W-1:0] byte_index;
  logic [BYTE_W-1:0]   tx_value;
  logic                tx_last;
  logic [BYTE_W-1:0]   status_code;
  logic [BYTE_W-1:0]   rx_value;

  modport source (
    output valid, op, byte_index, tx_value, tx_last, status_code, rx_value,
    input  ready
  );
  modport sink (
    input  valid, op, byte_index, tx_value, tx_last, status_code, rx_value,
    output ready
  );
endinterface

### design/ims_rsp_if.sv
// Result channel of the message sequencer: valid/ready plus result fields.
// Depends on ims_pkg.
interface ims_rsp_if;
  import ims_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  bus_action;
  logic [BYTE_W-1:0] tx_data;
  logic [LINK_W-1:0] link_status;
  logic [BYTE_W-1:0] msg_byte;
  logic              last;

  modport source (
    output valid, bus_action, tx_data, link_status, msg_byte, last,
    input  ready
  );
  modport sink (
    input  valid, bus_action, tx_data, link_status, msg_byte, last,
    output ready
  );
endinterface

### design/ims_front.sv
// Front end: accepts input items and turns each into a command kind.
// Depends on ims_pkg and ims_req_if.
module ims_front (
  ims_req_if.sink         req,
  input  ims_pkg::q_stat_t q_stat,
  output logic             push,
  output ims_pkg::cmd_t    push_cmd
);
  import ims_pkg::*;

  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data;

  assign req.ready = !q_stat.full;
  // Drop the unused op after the transfer: it has no result.
  assign push = req.valid && req.ready && (req.op != OP_UNUSED);

  always_comb begin
    kind = K_OTHER;
    data = req.rx_value;
    case (req.op)
      OP_WRITE: begin
        kind = req.tx_last ? K_WRITE_GO : K_WRITE;
        data = req.tx_value;
      end
      OP_FETCH: begin
        kind = K_FETCH;
      end
      OP_EVENT: begin
        case (req.status_code)
          ST_SR_STOP:                             kind = K_RX_STOP;
          ST_SR_SLA, ST_SR_GCALL:                 kind = K_RX_FIRST;
          ST_SR_DATA, ST_SR_GC_DATA:              kind = K_RX_DATA;
          ST_START, ST_RESTART:                   kind = K_MST_FIRST;
          ST_MT_SLA_ACK, ST_MT_DAT_ACK:           kind = K_MST_NEXT;
          ST_ARB_LOST, ST_SR_ARB_SLA, ST_SR_ARB_GC: kind = K_ARB;
          default:                                kind = K_OTHER;
        endcase
      end
      default: begin
        kind = K_OTHER;
      end
    endcase
  end

  assign push_cmd = '{kind: kind, idx: req.byte_index, data: data};

endmodule

### design/ims_fifo.sv
// Short command queue between the front end and the back end.
// Depends on ims_pkg.
module ims_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ims_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output ims_pkg::cmd_t    pop_cmd,
  output ims_pkg::q_stat_t q_stat
);
  import ims_pkg::*;

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  assign pop_cmd      = slots[rd_ptr];
  assign q_stat.full  = (count == (Q_AW + 1)'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

### design/ims_back.sv
// Back end: executes queued commands against the message buffers and
// link state, and holds the result register. Depends on ims_pkg, ims_rsp_if.
module ims_back #(
  parameter int MSG_BYTES = ims_pkg::MSG_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ims_pkg::q_stat_t q_stat,
  input  ims_pkg::cmd_t    pop_cmd,
  output logic             pop,
  ims_rsp_if.source        rsp
);
  import ims_pkg::*;

  localparam int IDX_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam logic [CNT_W-1:0] MSG_CNT  = CNT_W'(MSG_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_BYTES - 1);

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Message buffers
  logic [BYTE_W-1:0]    tx_mem [MSG_BYTES];
  logic [BYTE_W-1:0]    rx_mem [MSG_BYTES];
  logic [MSG_BYTES-1:0] rx_ok;

  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [LINK_W-1:0] link_state, link_next;
  logic [IDX_W-1:0]  fidx;

  // Result register
  logic              b_valid;
  logic [ACT_W-1:0]  b_act;
  logic [LINK_W-1:0] b_link;
  logic              b_last;
  logic              b_load;
  logic              b_fetch;
  logic [BYTE_W-1:0] rd_tx;
  logic [BYTE_W-1:0] rd_rx;
  logic              rd_rx_ok;

  logic              adv;
  logic              is_fetch;
  logic              fetch_end;
  logic [CNT_W-1:0]  bc0;
  logic [ACT_W-1:0]  act;
  logic              res_last;
  logic              is_load;
  logic              tx_we;
  logic              tx_re;
  logic [IDX_W-1:0]  tx_raddr;
  logic              rx_we;
  logic [IDX_W-1:0]  rx_waddr;
  logic [BYTE_W-1:0] rx_wdata;

  assign adv       = !q_stat.empty && (!b_valid || rsp.ready);
  assign is_fetch  = (pop_cmd.kind == K_FETCH);
  assign fetch_end = (fidx == LAST_IDX);
  // Hold a fetch at the queue head until its last byte goes out.
  assign pop       = adv && (!is_fetch || fetch_end);

  always_comb begin
    byte_count_next = byte_count;
    link_next       = link_state;
    bc0             = byte_count;
    act             = ACT_RELEASE;
    res_last        = 1'b1;
    is_load         = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    tx_raddr        = '0;
    rx_we           = 1'b0;
    rx_waddr        = fidx;
    rx_wdata        = pop_cmd.data;
    case (pop_cmd.kind)
      K_WRITE, K_WRITE_GO: begin
        act   = (pop_cmd.kind == K_WRITE_GO) ? ACT_START : ACT_NONE;
        tx_we = (CNT_W'(pop_cmd.idx) < MSG_CNT);
      end
      K_FETCH: begin
        act       = ACT_NONE;
        link_next = LINK_OFF;
        res_last  = fetch_end;
        rx_we     = 1'b1;
        rx_wdata  = 8'hFF;
      end
      K_RX_STOP: begin
        if (byte_count == MSG_CNT) link_next = LINK_RCV_END;
        byte_count_next = count_up(byte_count);
      end
      K_RX_DATA, K_RX_FIRST: begin
        if (pop_cmd.kind == K_RX_FIRST) bc0 = '0;
        link_next = LINK_RCV_ON;
        if (bc0 < MSG_CNT) begin
          rx_we    = 1'b1;
          rx_waddr = IDX_W'(bc0);
        end
        byte_count_next = count_up(bc0);
      end
      K_MST_NEXT, K_MST_FIRST: begin
        if (pop_cmd.kind == K_MST_FIRST) begin
          bc0       = '0;
          link_next = LINK_SND_ON;
        end
        if (bc0 >= MSG_CNT) begin
          byte_count_next = '0;
          link_next       = LINK_SND_END;
          act             = ACT_STOP;
        end else begin
          tx_re           = 1'b1;
          tx_raddr        = IDX_W'(bc0);
          byte_count_next = count_up(bc0);
          act             = ACT_LOAD;
          is_load         = 1'b1;
        end
      end
      K_ARB: begin
        act = ACT_RELEASE;
      end
      default: begin
        byte_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      link_state <= LINK_OFF;
      fidx       <= '0;
      b_valid    <= 1'b0;
      rx_ok      <= '0;
    end else begin
      if (adv) begin
        byte_count <= byte_count_next;
        link_state <= link_next;
        b_valid    <= 1'b1;
        if (is_fetch) fidx <= fetch_end ? '0 : fidx + 1'b1;
        if (rx_we) rx_ok[rx_waddr] <= 1'b1;
      end else if (rsp.ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_act   <= act;
      b_link  <= link_next;
      b_last  <= res_last;
      b_load  <= is_load;
      b_fetch <= is_fetch;
    end
  end

  // Buffer ports: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (adv && tx_we) tx_mem[IDX_W'(pop_cmd.idx)] <= pop_cmd.data;
    if (adv && tx_re) rd_tx <= tx_mem[tx_raddr];
  end

  always_ff @(posedge clk) begin
    if (adv && rx_we) rx_mem[rx_waddr] <= rx_wdata;
    if (adv && is_fetch) begin
      rd_rx    <= rx_mem[fidx];
      rd_rx_ok <= rx_ok[fidx];
    end
  end

  assign rsp.valid       = b_valid;
  assign rsp.bus_action  = b_act;
  assign rsp.tx_data     = b_load ? rd_tx : '0;
  assign rsp.link_status = b_link;
  // Entries never written since reset read as zero.
  assign rsp.msg_byte    = (b_fetch && rd_rx_ok) ? rd_rx : '0;
  assign rsp.last        = b_last;

endmodule

### design/i2c_message_sequencer.sv
// Top level of the two-wire message sequencer.
// Depends on ims_pkg, ims_req_if, ims_rsp_if, ims_front, ims_fifo, ims_back.
//
// Usage:
//   req carries host transmit-byte writes, controller status events and
//   fetch requests; rsp carries bus actions, link status and fetched bytes.
//   Both are valid/ready channels; a transfer happens when both are high.
//   An accepted item is written into the command queue and then executed
//   into the result register when that register is free or being taken.
//   Throughput: one item per cycle for writes and status events while
//   neither rsp nor the queue stalls; a fetch occupies the executing stage
//   for MSG_BYTES results, since the receive buffer is read one byte per
//   result. Unused op codes are taken and dropped with no result.
//   A four-entry command queue separates input from execution, so req
//   keeps accepting while a result waits on rsp.
//   When rsp stalls, the result register holds and the queue fills;
//   req.ready drops only when the queue is full.
//   Reset (synchronous, rst high) empties the queue, clears the byte
//   counter, sets the link status to off and makes the receive buffer read
//   as zero; the transmit buffer holds no defined value until written.
module i2c_message_sequencer #(
  parameter int MSG_BYTES = ims_pkg::MSG_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  ims_req_if.sink    req,
  ims_rsp_if.source  rsp
);
  import ims_pkg::*;

  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    pop_cmd;
  q_stat_t q_stat;

  ims_front u_front (
    .req      (req),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ims_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  ims_back #(
    .MSG_BYTES (MSG_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .pop_cmd (pop_cmd),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

### design/ims_check.sv
// Port-level checker for the message sequencer, bound to the top level.
// Depends on ims_pkg and i2c_message_sequencer_assert.svh.
`include "i2c_message_sequencer_assert.svh"

module ims_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [ims_pkg::ACT_W-1:0]  bus_action,
  input logic [ims_pkg::BYTE_W-1:0] tx_data,
  input logic [ims_pkg::LINK_W-1:0] link_status,
  input logic [ims_pkg::BYTE_W-1:0] msg_byte,
  input logic                       last
);
  import ims_pkg::*;

  `IMS_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(bus_action) && $stable(tx_data) && $stable(link_status) && $stable(msg_byte) && $stable(last), "stalled result changed")

  `IMS_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !rsp_valid, "result valid right after reset")

  `IMS_ASSERT(a_data_on_load, clk, rst, rsp_valid && (tx_data != '0) |-> bus_action == ACT_LOAD, "transmit data without a load action")

  `IMS_ASSERT(a_fetch_byte, clk, rst, rsp_valid && (msg_byte != '0) |-> bus_action == ACT_NONE && link_status == LINK_OFF, "fetched byte with wrong action or link")

  `IMS_ASSERT(a_stop_done, clk, rst, rsp_valid && bus_action == ACT_STOP |-> link_status == LINK_SND_END && last, "stop without send done")

endmodule

bind i2c_message_sequencer ims_check u_ims_check (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .bus_action  (rsp.bus_action),
  .tx_data     (rsp.tx_data),
  .link_status (rsp.link_status),
  .msg_byte    (rsp.msg_byte),
  .last        (rsp.last)
);

### sim/tb_i2c_message_sequencer.sv
`timescale 1ns / 100ps
// Testbench for the two-wire message sequencer: directed and random traffic with bursty
// input, random output stalls and a scoreboard that predicts every result.
// Depends on ims_pkg, ims_req_if, ims_rsp_if and i2c_message_sequencer.
module tb_i2c_message_sequencer;
  import ims_pkg::*;

  localparam int MSG_BYTES   = MSG_BYTES_DEF;
  localparam int RAND_ITEMS  = 470;
  localparam int SAT_EVENTS  = 262;
  localparam int END_SLACK   = 16;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [IDX_IN_W-1:0] byte_index;
    logic [BYTE_W-1:0]   tx_value;
    logic                tx_last;
    logic [BYTE_W-1:0]   status_code;
    logic [BYTE_W-1:0]   rx_value;
  } item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  bus_action;
    logic [BYTE_W-1:0] tx_data;
    logic [LINK_W-1:0] link_status;
    logic [BYTE_W-1:0] msg_byte;
    logic              last;
  } result_t;

  // Mirror of the sequencer state; holds the results still owed by the block.
  class link_mirror;
    logic [BYTE_W-1:0] tx_buf [MSG_BYTES];
    logic [BYTE_W-1:0] rx_buf [MSG_BYTES];
    logic [CNT_W-1:0]  count;
    logic [LINK_W-1:0] link;
    result_t           due[$];
    int                mismatches;

    function new();
      foreach (tx_buf[i]) tx_buf[i] = '0;
      foreach (rx_buf[i]) rx_buf[i] = '0;
      count      = '0;
      link       = LINK_OFF;
      mismatches = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void note_item(item_t it);
      result_t r;
      r = '{ACT_RELEASE, 8'h00, LINK_OFF, 8'h00, 1'b1};
      case (it.op)
        OP_WRITE: begin
          if (it.byte_index < MSG_BYTES) tx_buf[it.byte_index] = it.tx_value;
          r.bus_action  = it.tx_last ? ACT_START : ACT_NONE;
          r.link_status = link;
          due.push_back(r);
        end
        OP_FETCH: begin
          for (int i = 0; i < MSG_BYTES; i++) begin
            r = '{ACT_NONE, 8'h00, LINK_OFF, rx_buf[i], (i == MSG_BYTES - 1)};
            due.push_back(r);
          end
          foreach (rx_buf[i]) rx_buf[i] = 8'hFF;
          link = LINK_OFF;
        end
        OP_EVENT: begin
          case (it.status_code)
            ST_SR_STOP: begin
              if (count == MSG_BYTES) link = LINK_RCV_END;
              count = bump(count);
            end
            ST_SR_SLA, ST_SR_GCALL, ST_SR_DATA, ST_SR_GC_DATA: begin
              if (it.status_code == ST_SR_SLA || it.status_code == ST_SR_GCALL) count = '0;
              link = LINK_RCV_ON;
              if (count < MSG_BYTES) rx_buf[count] = it.rx_value;
              count = bump(count);
            end
            ST_START, ST_RESTART, ST_MT_SLA_ACK, ST_MT_DAT_ACK: begin
              if (it.status_code == ST_START || it.status_code == ST_RESTART) begin
                count = '0;
                link  = LINK_SND_ON;
              end
              if (count >= MSG_BYTES) begin
                // message fully sent: stop and report done
                count        = '0;
                link         = LINK_SND_END;
                r.bus_action = ACT_STOP;
              end else begin
                r.tx_data    = tx_buf[count];
                r.bus_action = ACT_LOAD;
                count        = bump(count);
              end
            end
            ST_ARB_LOST, ST_SR_ARB_SLA, ST_SR_ARB_GC: ;
            default: count = '0;
          endcase
          r.link_status = link;
          due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected result action=%0d data=%h link=%0d byte=%h last=%0b",
                         got.bus_action, got.tx_data, got.link_status, got.msg_byte, got.last));
      end else begin
        want = due.pop_front();
        if (got.bus_action !== want.bus_action)
          report($sformatf("bus_action %0d, want %0d", got.bus_action, want.bus_action));
        if (got.tx_data !== want.tx_data)
          report($sformatf("tx_data %h, want %h", got.tx_data, want.tx_data));
        if (got.link_status !== want.link_status)
          report($sformatf("link_status %0d, want %0d", got.link_status, want.link_status));
        if (got.msg_byte !== want.msg_byte)
          report($sformatf("msg_byte %h, want %h", got.msg_byte, want.msg_byte));
        if (got.last !== want.last)
          report($sformatf("last %0b, want %0b", got.last, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  ims_req_if req ();
  ims_rsp_if rsp ();

  i2c_message_sequencer #(.MSG_BYTES(MSG_BYTES)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  link_mirror mirror;
  int         items_sent;
  int         burst_left;
  int         cycle_count;
  int         stall_mode;
  int         stall_mode_left;
  int         stall_run;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver stalls: switch between free-running, random, sparse and long-run patterns.
  initial begin
    rsp.ready       = 1'b0;
    stall_mode      = 0;
    stall_mode_left = 0;
    stall_run       = 0;
  end

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(40, 160);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= 1'($urandom_range(0, 1));
      2: rsp.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        // hold the current level for a run, then flip
        if (stall_run == 0) begin
          rsp.ready <= ~rsp.ready;
          stall_run = $urandom_range(1, 20);
        end else begin
          stall_run--;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      mirror.note_item('{req.op, req.byte_index, req.tx_value, req.tx_last,
                         req.status_code, req.rx_value});
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      mirror.check_result('{rsp.bus_action, rsp.tx_data, rsp.link_status,
                            rsp.msg_byte, rsp.last});
  end

  // Unused fields carry random noise in every item.
  function automatic item_t random_item();
    item_t it;
    it.op          = OP_W'($urandom_range(0, 3));
    it.byte_index  = IDX_IN_W'($urandom_range(0, 7));
    it.tx_value    = BYTE_W'($urandom_range(0, 255));
    it.tx_last     = 1'($urandom_range(0, 1));
    it.status_code = BYTE_W'($urandom_range(0, 255));
    it.rx_value    = BYTE_W'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t write_item(int idx, logic [BYTE_W-1:0] value, bit go);
    item_t it;
    it            = random_item();
    it.op         = OP_WRITE;
    it.byte_index = IDX_IN_W'(idx);
    it.tx_value   = value;
    it.tx_last    = go;
    return it;
  endfunction

  function automatic item_t event_item(logic [BYTE_W-1:0] code, logic [BYTE_W-1:0] rx);
    item_t it;
    it             = random_item();
    it.op          = OP_EVENT;
    it.status_code = code;
    it.rx_value    = rx;
    return it;
  endfunction

  function automatic item_t fetch_item();
    item_t it;
    it    = random_item();
    it.op = OP_FETCH;
    return it;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    req.valid       <= 1'b1;
    req.op          <= it.op;
    req.byte_index  <= it.byte_index;
    req.tx_value    <= it.tx_value;
    req.tx_last     <= it.tx_last;
    req.status_code <= it.status_code;
    req.rx_value    <= it.rx_value;
    do @(posedge clk); while (!req.ready);
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  // Hold off the sender until the block owes nothing.
  task automatic wait_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
    burst_left = 0;
  endtask

  // Write the whole outgoing message in shuffled order, usually with a start request on the final write.
  task automatic load_message();
    int order[MSG_BYTES];
    int j;
    int tmp;
    foreach (order[i]) order[i] = i;
    for (int i = MSG_BYTES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < MSG_BYTES; i++) begin
      if ($urandom_range(0, 5) == 0)
        send(write_item($urandom_range(MSG_BYTES, 7), rand_byte(), 1'($urandom_range(0, 1))));
      send(write_item(order[i], rand_byte(),
                      (i == MSG_BYTES - 1) ? ($urandom_range(0, 7) != 0) : 1'b0));
    end
  endtask

  task automatic master_send();
    send(event_item($urandom_range(0, 1) ? ST_START : ST_RESTART, rand_byte()));
    send(event_item(ST_MT_SLA_ACK, rand_byte()));
    for (int n = 0; n < MSG_BYTES - 1; n++) begin
      if ($urandom_range(0, 19) == 0)
        send(event_item(ST_ARB_LOST, rand_byte()));
      else if ($urandom_range(0, 29) == 0)
        send(event_item(rand_byte(), rand_byte()));
      send(event_item(ST_MT_DAT_ACK, rand_byte()));
    end
  endtask

  task automatic slave_receive();
    int n;
    if ($urandom_range(0, 7) == 0)
      send(event_item($urandom_range(0, 1) ? ST_SR_ARB_SLA : ST_SR_ARB_GC, rand_byte()));
    send(event_item($urandom_range(0, 1) ? ST_SR_SLA : ST_SR_GCALL, rand_byte()));
    n = ($urandom_range(0, 9) < 7) ? MSG_BYTES - 1 : $urandom_range(0, MSG_BYTES + 2);
    repeat (n) send(event_item($urandom_range(0, 1) ? ST_SR_DATA : ST_SR_GC_DATA, rand_byte()));
    send(event_item(ST_SR_STOP, rand_byte()));
    if ($urandom_range(0, 9) < 7) send(fetch_item());
  endtask

  task automatic noise();
    item_t it;
    repeat ($urandom_range(1, 4)) begin
      it = random_item();
      // bias status codes toward the defined ones
      if (it.op == OP_EVENT && $urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0: it.status_code = ST_SR_STOP;
          1: it.status_code = ST_ARB_LOST;
          2: it.status_code = ST_SR_DATA;
          3: it.status_code = ST_MT_DAT_ACK;
          4: it.status_code = ST_SR_ARB_GC;
          default: it.status_code = ST_START;
        endcase
      end
      send(it);
    end
  endtask

  // Drive the byte counter into saturation, then let a master acknowledgement end it.
  task automatic saturate_count();
    send(event_item(ST_SR_SLA, rand_byte()));
    repeat (SAT_EVENTS) begin
      case ($urandom_range(0, 9))
        0: send(event_item(ST_SR_STOP, rand_byte()));
        1: send(event_item(ST_SR_GC_DATA, rand_byte()));
        default: send(event_item(ST_SR_DATA, rand_byte()));
      endcase
    end
    send(event_item(ST_SR_ARB_SLA, rand_byte()));
    send(event_item(ST_SR_STOP, rand_byte()));
    send(event_item(ST_MT_DAT_ACK, rand_byte()));
    send(fetch_item());
  endtask

  initial begin
    int pick;
    item_t odd;
    mirror          = new();
    items_sent      = 0;
    burst_left      = 0;
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.op          = OP_WRITE;
    req.byte_index  = '0;
    req.tx_value    = '0;
    req.tx_last     = 1'b0;
    req.status_code = '0;
    req.rx_value    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset buffer, full message write, out-of-range writes, a full master
    // message with arbitration loss, a complete slave message, fetch, odd codes.
    send(fetch_item());
    send(write_item(0, 8'h00, 1'b0));
    send(write_item(1, 8'hFF, 1'b0));
    send(write_item(2, 8'hA5, 1'b0));
    send(write_item(3, 8'h5A, 1'b0));
    send(write_item(4, 8'h3C, 1'b1));
    send(write_item(7, 8'hFF, 1'b1));
    send(write_item(5, 8'h81, 1'b0));
    send(event_item(ST_START, 8'h00));
    send(event_item(ST_MT_SLA_ACK, 8'hFF));
    send(event_item(ST_ARB_LOST, 8'h00));
    send(event_item(ST_MT_DAT_ACK, 8'h00));
    send(event_item(ST_MT_DAT_ACK, 8'h00));
    send(event_item(ST_MT_DAT_ACK, 8'h00));
    send(event_item(ST_MT_DAT_ACK, 8'h00));
    send(event_item(ST_SR_GCALL, 8'hFF));
    send(event_item(ST_SR_DATA, 8'h00));
    send(event_item(ST_SR_GC_DATA, 8'h81));
    send(event_item(ST_SR_DATA, 8'h7E));
    send(event_item(ST_SR_DATA, 8'h01));
    send(event_item(ST_SR_STOP, 8'h00));
    send(fetch_item());
    odd    = random_item();
    odd.op = OP_UNUSED;
    send(odd);
    send(event_item(8'h00, 8'hFF));
    send(event_item(ST_SR_ARB_SLA, 8'h55));
    send(event_item(ST_SR_ARB_GC, 8'hAA));
    wait_drained();

    saturate_count();
    while (items_sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        load_message();
        master_send();
      end else if (pick < 45) begin
        slave_receive();
      end else if (pick < 55) begin
        load_message();
      end else if (pick < 65) begin
        master_send();
      end else if (pick < 73) begin
        send(fetch_item());
      end else if (pick < 93) begin
        noise();
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (END_SLACK) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
